// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the preview range query RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRMMQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wrmmq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WRMMQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wrmmq: next-cycle check failed");

`endif

// ===== hdl/wrmmq_pkg.sv =====
// Types and constants of the waveform preview range query block.
`timescale 1ns / 1ps
`default_nettype none

package wrmmq_pkg;

  localparam int MAX_ENTRIES_DEF = 4096;

  localparam int STREAM_LENGTH_W = 32;
  localparam int ENTRY_COUNT_W   = 13;
  localparam int ENTRY_INDEX_W   = 12;
  localparam int CODE_W          = 8;
  localparam int TIME_W          = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT   = 1'b1;

  // Input word actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CODE_W-1:0] CODE_MAX = '1;

  typedef struct packed {
    logic                     action;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [CODE_W-1:0]        entry_min;
    logic [CODE_W-1:0]        entry_max;
    logic signed [TIME_W-1:0] time_start;
    logic signed [TIME_W-1:0] time_end;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] range_min;
    logic [CODE_W-1:0] range_max;
    logic              empty_res;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/wrmmq_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
`default_nettype none

interface wrmmq_in_if;
  import wrmmq_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wrmmq_out_if;
  import wrmmq_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/waveform_range_min_max_query.sv =====
// Waveform preview table with min/max range query over a time window.
// Usage:
//   in_i carries write and query words. A write word stores one {min, max}
//   entry into the preview table in the cycle it is taken and gives no result.
//   A query word maps time_start and time_end (Q16.16) to table indexes as
//   time * count / length, clamps them, and scans the half-open range.
//   out_o carries one result word per query: smallest min, largest max, and
//   empty_res when length or count is zero.
//   The cfg port writes stream_length (index 0) and entry_count (index 1).
// Timing:
//   A query maps both times with two bit-per-cycle dividers that run side by
//   side over N_W = $clog2(MAX_ENTRIES + 1) quotient bits (13 at the default
//   size), then reads the scanned entries from the table RAM one per cycle.
//   An empty query skips the division and the scan and goes straight to the
//   result. One word is in flight at a time.
// Reset:
//   Clears both registers to zero and the control state. Table contents are
//   undefined until written; there is no clearing pass.
// Stall: a result waits in the output register; writes are still taken
//   meanwhile, and a following query holds its result until it frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module waveform_range_min_max_query #(
  parameter int MAX_ENTRIES = wrmmq_pkg::MAX_ENTRIES_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [wrmmq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [wrmmq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  wrmmq_in_if.sink                          in_i,
  wrmmq_out_if.source                       out_o
);
  import wrmmq_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int N_W    = $clog2(MAX_ENTRIES + 1);
  localparam int T_W    = TIME_W - 1;
  localparam int PROD_W = T_W + N_W;
  localparam int CNT_W  = $clog2(N_W + 1);
  localparam int WORD_W = 2 * CODE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_CLAMP = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  // Configuration
  logic [STREAM_LENGTH_W-1:0] stream_length_q;
  logic [ENTRY_COUNT_W-1:0]   entry_count_q;
  logic [N_W-1:0]             n_cnt;

  // Control
  logic [2:0]       state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   ptr_q;
  logic [N_W-1:0]   hi_q;
  logic             rd_vld_q;
  logic             out_vld_q;

  // Table RAM
  logic [WORD_W-1:0] tbl_mem_q [MAX_ENTRIES];
  logic [WORD_W-1:0] rd_word_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  // Divider lanes: 0 maps the start time, 1 the end time
  logic [TIME_W-1:0]          time_in [2];
  logic [T_W-1:0]             t_q     [2];
  logic [1:0]                 neg_q;
  logic [1:0]                 over_q;
  logic [STREAM_LENGTH_W-1:0] rem_q   [2];
  logic [N_W-1:0]             low_q   [2];
  logic [N_W-1:0]             quo_q   [2];
  logic [T_W-1:0]             t_eff   [2];
  logic [PROD_W-1:0]          prod    [2];
  logic [STREAM_LENGTH_W:0]   trial   [2];
  logic [1:0]                 ge;
  logic [STREAM_LENGTH_W-1:0] rem_d   [2];
  logic [N_W-1:0]             idx     [2];
  logic [N_W-1:0]             hi_d;

  // Result
  logic [CODE_W-1:0] acc_min_q;
  logic [CODE_W-1:0] acc_max_q;
  logic              empty_q;
  out_word_t         out_word_q;

  logic in_acc;
  logic is_query;
  logic empty_cfg;
  logic out_free;

  assign n_cnt = (32'(entry_count_q) > 32'(MAX_ENTRIES)) ? N_W'(MAX_ENTRIES)
                                                          : N_W'(entry_count_q);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign is_query    = (in_i.data.action == ACT_QUERY);
  assign empty_cfg   = (stream_length_q == '0) || (n_cnt == '0);
  assign out_free    = !out_vld_q || out_o.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_word_q;

  assign wr_en   = in_acc && (in_i.data.action == ACT_WRITE) &&
                   (32'(in_i.data.entry_index) < 32'(MAX_ENTRIES));
  assign wr_addr = IDX_W'(in_i.data.entry_index);

  assign time_in[0] = in_i.data.time_start;
  assign time_in[1] = in_i.data.time_end;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      t_eff[k] = (neg_q[k] || over_q[k]) ? '0 : t_q[k];
      prod[k]  = PROD_W'(t_eff[k]) * PROD_W'(n_cnt);
      trial[k] = {rem_q[k], low_q[k][N_W-1]};
      ge[k]    = trial[k] >= {1'b0, stream_length_q};
      rem_d[k] = ge[k] ? STREAM_LENGTH_W'(trial[k] - {1'b0, stream_length_q})
                       : trial[k][STREAM_LENGTH_W-1:0];
      if (neg_q[k]) begin
        idx[k] = '0;
      end else if (over_q[k]) begin
        idx[k] = n_cnt - N_W'(1);
      end else begin
        idx[k] = quo_q[k];
      end
    end
    // A reversed or empty window still covers one entry
    hi_d = (idx[1] <= idx[0]) ? idx[0] + N_W'(1) : idx[1];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_length_q <= '0;
      entry_count_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STREAM_LENGTH: stream_length_q <= cfg_data_i[STREAM_LENGTH_W-1:0];
        REG_ENTRY_COUNT:   entry_count_q   <= cfg_data_i[ENTRY_COUNT_W-1:0];
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      ptr_q     <= '0;
      hi_q      <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && is_query) begin
            state_q <= empty_cfg ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(N_W - 1)) begin
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          ptr_q   <= idx[0];
          hi_q    <= hi_d;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          ptr_q <= ptr_q + N_W'(1);
          if (ptr_q + N_W'(1) == hi_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Table RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem_q[wr_addr] <= {in_i.data.entry_max, in_i.data.entry_min};
    end
    rd_word_q <= tbl_mem_q[ptr_q[IDX_W-1:0]];
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      for (int k = 0; k < 2; k++) begin
        t_q[k]    <= time_in[k][T_W-1:0];
        neg_q[k]  <= time_in[k][TIME_W-1];
        over_q[k] <= {1'b0, time_in[k][T_W-1:0]} >= stream_length_q;
      end
      empty_q   <= empty_cfg;
      acc_min_q <= empty_cfg ? '0 : CODE_MAX;
      acc_max_q <= '0;
    end else if (rd_vld_q) begin
      if (rd_word_q[CODE_W-1:0] < acc_min_q) begin
        acc_min_q <= rd_word_q[CODE_W-1:0];
      end
      if (rd_word_q[WORD_W-1:CODE_W] > acc_max_q) begin
        acc_max_q <= rd_word_q[WORD_W-1:CODE_W];
      end
    end

    if (state_q == ST_MUL) begin
      for (int k = 0; k < 2; k++) begin
        rem_q[k] <= STREAM_LENGTH_W'(prod[k] >> N_W);
        low_q[k] <= prod[k][N_W-1:0];
        quo_q[k] <= '0;
      end
    end else if (state_q == ST_DIV) begin
      for (int k = 0; k < 2; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_q[k] << 1;
        quo_q[k] <= {quo_q[k][N_W-2:0], ge[k]};
      end
    end

    if (state_q == ST_FIN && out_free) begin
      out_word_q.range_min <= acc_min_q;
      out_word_q.range_max <= acc_max_q;
      out_word_q.empty_res <= empty_q;
    end
  end

  `WRMMQ_ASSERT_IMP(a_div_rem_below_len, clk_i, rst_ni, state_q == ST_DIV,
    rem_q[0] < stream_length_q && rem_q[1] < stream_length_q)
  `WRMMQ_ASSERT_IMP(a_scan_in_table, clk_i, rst_ni, state_q == ST_SCAN,
    ptr_q < hi_q && hi_q <= n_cnt)
  `WRMMQ_ASSERT_IMP(a_empty_only_cfg, clk_i, rst_ni, state_q == ST_FIN && empty_q,
    stream_length_q == '0 || n_cnt == '0)
  `WRMMQ_ASSERT_IMP(a_drain_has_data, clk_i, rst_ni, state_q == ST_DRAIN, rd_vld_q)
  `WRMMQ_ASSERT_NXT(a_query_goes_busy, clk_i, rst_ni, in_acc && is_query,
    state_q != ST_IDLE)

endmodule

`default_nettype wire
